// File: src/nal_length_to_start_code_core_macros.svh
// ---------------------------------------------------------------------------
// NAL length to start code: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NAL_LENGTH_TO_START_CODE_CORE_MACROS_SVH
`define NAL_LENGTH_TO_START_CODE_CORE_MACROS_SVH

// same-cycle implication
`define NL2SC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NL2SC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nl2sc_pkg.sv
// ---------------------------------------------------------------------------
// nl2sc_pkg
// Types and constants shared by the NAL length to start code converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nl2sc_pkg;

  typedef enum logic {
    PH_PREFIX  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  localparam logic [2:0] PFX_MIN      = 3'd1;
  localparam logic [2:0] PFX_MAX      = 3'd4;
  localparam logic [2:0] PFX_RESET    = 3'd4;
  localparam logic [2:0] SC_LONG_LEN  = 3'd4;
  localparam logic [2:0] SC_SHORT_LEN = 3'd3;
  localparam logic [7:0] SC_ZERO      = 8'h00;
  localparam logic [7:0] SC_ONE       = 8'h01;

  // One burst of results: cnt items, all 00 data bytes except the final one.
  typedef struct packed {
    logic [2:0] cnt;
    logic [7:0] fin_byte;
    logic       fin_valid;
    logic       fin_last;
    logic       fin_err;
  } burst_t;

endpackage

// File: src/nl2sc_burst_out.sv
// ---------------------------------------------------------------------------
// nl2sc_burst_out
// Result register: holds a burst, sends a transaction a cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nl2sc_burst_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  nl2sc_pkg::burst_t burst,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last_of_packet,
  output logic             out_packet_error
);
  import nl2sc_pkg::*;

  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] fin_byte_r;
  logic       fin_valid_r, fin_last_r, fin_err_r;
  logic       out_acc;
  logic       at_fin;

  assign out_valid = (cnt_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;
  assign at_fin    = (cnt_r == 3'd1);
  assign can_load  = (cnt_r == 3'd0) || (at_fin && !out_stall);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = burst.cnt;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin_byte_r  <= burst.fin_byte;
      fin_valid_r <= burst.fin_valid;
      fin_last_r  <= burst.fin_last;
      fin_err_r   <= burst.fin_err;
    end
  end

  assign out_byte           = at_fin ? fin_byte_r : SC_ZERO;
  assign out_byte_valid     = at_fin ? fin_valid_r : 1'b1;
  assign out_last_of_packet = at_fin && fin_last_r;
  assign out_packet_error   = at_fin && fin_err_r;

endmodule

// File: src/nal_length_to_start_code_core.sv
// The first result appears in the cycle after the input transaction is accepted.
// One payload byte per cycle while the output does not stall; a completed length
// prefix yields a 3 or 4 byte start code burst played out by the result
// register, so the input stalls at each unit boundary until the burst's last byte.
// Reset (rst_n, synchronous, active low): prefix size 4, parser idle at the
// start of a packet, result register empty.
// ---------------------------------------------------------------------------
// nal_length_to_start_code_core
// Converts length-prefixed NAL units into start-code framed byte stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nal_length_to_start_code_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_length_prefix_bytes,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_packet,
  output logic       out_packet_error
);
  import nl2sc_pkg::*;

  `include "nal_length_to_start_code_core_macros.svh"

  logic [2:0]  pfx_bytes_r;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        first_r, first_nxt;

  logic [2:0]  size;
  logic [31:0] rem_dec, rem_sh;
  logic [2:0]  pc_inc;
  logic        pfx_done;
  logic        in_acc;
  logic        can_load;
  burst_t      burst;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign in_acc    = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_bytes_r <= PFX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pfx_bytes_r <= cfg_length_prefix_bytes;
    end
  end

  always_comb begin
    case (pfx_bytes_r) inside
      3'd0:         size = PFX_MIN;
      [3'd1:3'd4]:  size = pfx_bytes_r;
      default:      size = PFX_MAX;
    endcase
  end

  assign rem_dec  = rem_r - 32'd1;
  assign rem_sh   = {rem_r[23:0], in_byte};
  assign pc_inc   = pcnt_r + 3'd1;
  assign pfx_done = (pc_inc >= size);

  // next parser state
  always_comb begin
    phase_nxt = phase_r;
    pcnt_nxt  = pcnt_r;
    rem_nxt   = rem_r;
    first_nxt = first_r;
    if (in_acc) begin
      if (phase_r == PH_PAYLOAD) begin
        rem_nxt   = rem_dec;
        phase_nxt = (rem_dec == 32'd0) ? PH_PREFIX : PH_PAYLOAD;
      end else begin
        rem_nxt = rem_sh;
        if (pfx_done) begin
          pcnt_nxt  = 3'd0;
          first_nxt = 1'b1;
          phase_nxt = (rem_sh != 32'd0) ? PH_PAYLOAD : PH_PREFIX;
        end else begin
          pcnt_nxt = pc_inc;
        end
      end
      if (in_last) begin
        phase_nxt = PH_PREFIX;
        pcnt_nxt  = 3'd0;
        rem_nxt   = 32'd0;
        first_nxt = 1'b0;
      end
    end
  end

  // result burst for the accepted byte
  always_comb begin
    burst.cnt       = 3'd0;
    burst.fin_byte  = in_byte;
    burst.fin_valid = 1'b1;
    burst.fin_last  = in_last;
    burst.fin_err   = 1'b0;
    if (phase_r == PH_PAYLOAD) begin
      burst.cnt     = 3'd1;
      burst.fin_err = in_last && (rem_dec != 32'd0);
    end else if (pfx_done) begin
      burst.cnt      = first_r ? SC_SHORT_LEN : SC_LONG_LEN;
      burst.fin_byte = SC_ONE;
      burst.fin_err  = in_last && (rem_sh != 32'd0);
    end else if (in_last) begin
      burst.cnt       = 3'd1;
      burst.fin_byte  = SC_ZERO;
      burst.fin_valid = 1'b0;
      burst.fin_err   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      pcnt_r  <= 3'd0;
      rem_r   <= 32'd0;
      first_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pcnt_r  <= pcnt_nxt;
      rem_r   <= rem_nxt;
      first_r <= first_nxt;
    end
  end

  nl2sc_burst_out u_burst_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (in_acc),
    .burst              (burst),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last_of_packet (out_last_of_packet),
    .out_packet_error   (out_packet_error)
  );

  `NL2SC_ASSERT_IMP(a_payload_nonzero, phase_r == PH_PAYLOAD, rem_r != 32'd0, "payload phase with zero length left")
  `NL2SC_ASSERT_IMP(a_err_on_last, out_valid && out_packet_error, out_last_of_packet, "packet error off the final transaction")
  `NL2SC_ASSERT_IMP(a_marker_is_err, out_valid && !out_byte_valid, out_packet_error && out_last_of_packet, "error marker without error and last")
  `NL2SC_ASSERT_NXT(a_pkt_end_clear, in_acc && in_last, phase_r == PH_PREFIX && pcnt_r == 3'd0 && !first_r, "parser not cleared after packet end")

endmodule

// File: test/nal_length_to_start_code_core_test.sv
// ---------------------------------------------------------------------------
// nal_length_to_start_code_core_test
// Self-checking bench for the NAL length to start code converter. A byte-level
// model predicts the start code framing per input transaction and compares it
// field by field against every output transaction. Directed corner packets
// run first, then random packets over all prefix size settings with random
// idle/stall, a long output hold-off and a stretch at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nal_length_to_start_code_core_test;
  import nl2sc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 6;
  localparam int PHASE_ITEMS = 60;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } frame_item_t;

  class start_code_scoreboard;
    phase_t      phase;
    logic [2:0]  prefix_cnt;
    logic [31:0] remaining;
    logic        started;
    logic [2:0]  prefix_size;
    frame_item_t expected_bytes[$];
    int          mismatches;

    function new();
      prefix_size = PFX_RESET;
      mismatches  = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      phase      = PH_PREFIX;
      prefix_cnt = '0;
      remaining  = '0;
      started    = 1'b0;
    endfunction

    function void set_prefix_size(logic [2:0] v);
      prefix_size = v;
    endfunction

    function int unit_size();
      if (prefix_size < PFX_MIN) return PFX_MIN;
      if (prefix_size > PFX_MAX) return PFX_MAX;
      return prefix_size;
    endfunction

    function void push_item(logic [7:0] d, logic v, logic l, logic e);
      frame_item_t it;
      it.data  = d;
      it.valid = v;
      it.last  = l;
      it.err   = e;
      expected_bytes.push_back(it);
    endfunction

    function void note_input(logic [7:0] b, logic l);
      if (phase == PH_PAYLOAD) begin
        remaining = remaining - 1;
        if (remaining == 0) phase = PH_PREFIX;
        push_item(b, 1'b1, l, l && remaining != 0);
      end else begin
        remaining  = {remaining[23:0], b};
        prefix_cnt = prefix_cnt + 3'd1;
        if (prefix_cnt >= unit_size()) begin
          if (!started) push_item(SC_ZERO, 1'b1, 1'b0, 1'b0);
          push_item(SC_ZERO, 1'b1, 1'b0, 1'b0);
          push_item(SC_ZERO, 1'b1, 1'b0, 1'b0);
          push_item(SC_ONE, 1'b1, l, l && remaining != 0);
          started    = 1'b1;
          prefix_cnt = '0;
          if (remaining != 0) phase = PH_PAYLOAD;
        end else if (l) begin
          push_item(SC_ZERO, 1'b0, 1'b1, 1'b1);
        end
      end
      if (l) clear_packet();
    endfunction

    function void check_result(logic [7:0] d, logic v, logic l, logic e);
      frame_item_t exp_item;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: byte=%02h valid=%b last=%b err=%b", d, v, l, e);
        return;
      end
      exp_item = expected_bytes.pop_front();
      if (d !== exp_item.data || v !== exp_item.valid || l !== exp_item.last ||
          e !== exp_item.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte=%02h valid=%b last=%b err=%b, got %02h %b %b %b",
                   exp_item.data, exp_item.valid, exp_item.last, exp_item.err, d, v, l, e);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_length_prefix_bytes = PFX_RESET;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last_of_packet;
  logic       out_packet_error;

  start_code_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_long = 1'b0;

  nal_length_to_start_code_core dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_length_prefix_bytes (cfg_length_prefix_bytes),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_byte                 (in_byte),
    .in_last                 (in_last),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_byte                (out_byte),
    .out_byte_valid          (out_byte_valid),
    .out_last_of_packet      (out_last_of_packet),
    .out_packet_error        (out_packet_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_result(out_byte, out_byte_valid, out_last_of_packet, out_packet_error);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: per-transaction stall, with an optional long hold-off
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (hold_long) begin
        hold = HOLD_CYCLES;
        hold_long = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(b, l);
    items_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_prefix_size(input logic [2:0] v);
    drain();
    cfg_valid               <= 1'b1;
    cfg_length_prefix_bytes <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_prefix_size(v);
  endtask

  function automatic void add_unit(ref byte_q_t q, input int size, input logic [31:0] len);
    for (int i = size - 1; i >= 0; i--) q.push_back(len[8*i +: 8]);
    for (int i = 0; i < len; i++) q.push_back(8'($urandom));
  endfunction

  task automatic send_random_packet();
    byte_q_t     pkt;
    int          kind;
    int          cut;
    int          sz;
    logic [31:0] len;
    sz   = sb.unit_size();
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
    end else if (kind == 1) begin
      // nonzero length, mostly beyond the end of the packet
      pkt.push_back(8'($urandom_range(1, 255)));
      repeat (sz - 1) pkt.push_back(8'($urandom));
      repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
        add_unit(pkt, sz, len);
      end
      if (kind == 2) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end
    send_packet(pkt);
  endtask

  initial begin
    logic [2:0] phase_sizes[8] = '{3'd3, 3'd1, 3'd2, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7};
    int         phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset prefix size: first and later start codes, zero-length final unit
    send_packet('{8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00});
    // truncated inside payload
    write_prefix_size(3'd1);
    send_packet('{8'h03, 8'haa, 8'h55});
    // ends right after a nonzero prefix
    send_packet('{8'h05});
    // ends inside a prefix
    write_prefix_size(3'd2);
    send_packet('{8'hff});
    // size 0 acts as 1; zero-length single unit
    write_prefix_size(3'd0);
    send_packet('{8'h00});
    // size above 4 acts as 4; huge length
    write_prefix_size(3'd7);
    send_packet('{8'hff, 8'hff, 8'hff, 8'hff, 8'h01});
    // prefix size shrinks mid-prefix
    write_prefix_size(3'd4);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    write_prefix_size(3'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);

    foreach (phase_sizes[p]) begin
      write_prefix_size(phase_sizes[p]);
      steady    = (p == 4);
      hold_long = (p == 2);
      phase_start = items_sent;
      while (items_sent < phase_start + PHASE_ITEMS) send_random_packet();
      // sender waits for every pending result mid-phase once
      if (p == 5) begin
        drain();
        repeat (4) send_random_packet();
      end
    end
    steady = 1'b0;

    drain();
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
